### design/ctp_pkg.sv
// Package of the climb, pitch and throttle controller: constants, types and codes.
`timescale 1ns / 1ps
package ctp_pkg;

   localparam int LOOP_FREQ          = 512;
   localparam int MAX_THROTTLE       = 9600;
   localparam int THROTTLE_KD        = 0;
   localparam int PITCH_BIAS         = 0;
   localparam int PITCH_PER_CLIMB    = 5719;
   localparam int THROTTLE_PER_CLIMB = 6554;
   localparam int PITCH_SUM_LIMIT    = 11438;
   localparam int THROTTLE_SUM_LIMIT = 26214;

   localparam int DATA_W     = 32;
   localparam int GAIN_W     = 31;
   localparam int CRUISE_W   = 17;
   localparam int THR_W      = 14;
   localparam int ACC_W      = 36;
   localparam int PROD_W     = 64;
   localparam int DIV_W      = 31;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 31;

   // Largest positive throttle sum whose scaled value does not exceed the maximum.
   localparam longint THR_SUM_MAX =
      ((longint'(MAX_THROTTLE) + 64'sd1) * 64'sd65536 - 64'sd1) / longint'(MAX_THROTTLE);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CLIMB_GAIN    = 3'd0,
      CSR_CLIMB_LIMIT   = 3'd1,
      CSR_PITCH_KP      = 3'd2,
      CSR_PITCH_KD      = 3'd3,
      CSR_PITCH_KI      = 3'd4,
      CSR_THROTTLE_KP   = 3'd5,
      CSR_THROTTLE_KI   = 3'd6,
      CSR_BASE_THROTTLE = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_MANUAL   = 2'd0,
      KIND_ALTITUDE = 2'd1,
      KIND_CLIMB    = 2'd2,
      KIND_OTHER    = 2'd3
   } kind_type;

   typedef struct packed {
      logic [GAIN_W-1:0]   climb_gain;
      logic [GAIN_W-1:0]   climb_limit;
      logic [GAIN_W-1:0]   pitch_kp;
      logic [GAIN_W-1:0]   pitch_kd;
      logic [GAIN_W-1:0]   pitch_ki;
      logic [GAIN_W-1:0]   throttle_kp;
      logic [GAIN_W-1:0]   throttle_ki;
      logic [CRUISE_W-1:0] base_throttle;
   } cfg_type;

   typedef struct packed {
      logic [1:0]               kind;
      logic                     airborne;
      logic signed [DATA_W-1:0] target_altitude;
      logic signed [DATA_W-1:0] climb_request;
      logic [THR_W-1:0]         manual_throttle;
      logic signed [DATA_W-1:0] pitch_feedforward;
      logic signed [DATA_W-1:0] altitude;
      logic signed [DATA_W-1:0] vertical_speed;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] pitch_command;
      logic [THR_W-1:0]         throttle_command;
      logic signed [DATA_W-1:0] climb_target;
   } rsp_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_MANUAL,
      OP_MUL_ALT,
      OP_SETPOINT,
      OP_ERROR,
      OP_DERR,
      OP_INT_P,
      OP_PPC,
      OP_PKP,
      OP_PKD,
      OP_PKI,
      OP_TPC,
      OP_TKP,
      OP_TKD,
      OP_TACC,
      OP_INT_T,
      OP_TKI,
      OP_TSUM,
      OP_THR_MUL,
      OP_THR_END
   } op_type;

   typedef struct packed {
      op_type op;
      logic   div_start;
      logic   div_throttle;
      logic   out_load;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic out_free;
   } status_type;

endpackage

### design/ctp_if.sv
// Valid/ready channel interfaces for control ticks and their results.
`timescale 1ns / 1ps
interface ctp_req_if;
   logic             valid;
   logic             ready;
   ctp_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface ctp_rsp_if;
   logic             valid;
   logic             ready;
   ctp_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### design/ctp_div.sv
// Restoring divider that yields one quotient bit per cycle for the integrator limits.
`timescale 1ns / 1ps
module ctp_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [ctp_pkg::DIV_W-1:0] numerator,
   input  logic [ctp_pkg::DIV_W-1:0] divisor,
   output logic                      busy,
   output logic [ctp_pkg::DIV_W-1:0] quotient
);

   localparam int CNT_W = $clog2(ctp_pkg::DIV_W);

   logic                      busy_ff;
   logic [CNT_W-1:0]          count_ff;
   logic [ctp_pkg::DIV_W-1:0] shift_ff;
   logic [ctp_pkg::DIV_W-1:0] rem_ff;
   logic [ctp_pkg::DIV_W-1:0] div_ff;
   logic [ctp_pkg::DIV_W:0]   trial;
   logic                      fits;

   assign trial = {rem_ff, shift_ff[ctp_pkg::DIV_W-1]};
   assign fits  = trial >= {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else if (start) begin
         busy_ff  <= 1'b1;
         count_ff <= CNT_W'(ctp_pkg::DIV_W - 1);
      end else if (busy_ff) begin
         count_ff <= count_ff - 1'b1;
         if (count_ff == '0) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         shift_ff <= numerator;
         rem_ff   <= '0;
         div_ff   <= divisor;
      end else if (busy_ff) begin
         shift_ff <= {shift_ff[ctp_pkg::DIV_W-2:0], fits};
         rem_ff   <= fits ? ctp_pkg::DIV_W'(trial - {1'b0, div_ff})
                          : trial[ctp_pkg::DIV_W-1:0];
      end
   end

   assign busy     = busy_ff;
   assign quotient = shift_ff;

endmodule

### design/ctp_dp.sv
// Datapath: shared multiplier, accumulator, loop state and the limit divider.
`timescale 1ns / 1ps
module ctp_dp (
   input  logic             clock,
   input  logic             reset,
   input  ctp_pkg::cfg_type cfg,
   input  logic             load,
   input  ctp_pkg::req_type item,
   input  ctp_pkg::cmd_type cmd,
   output logic             div_busy,
   output ctp_pkg::rsp_type result
);

   localparam int W = ctp_pkg::DATA_W;

   function automatic logic signed [W-1:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         return 32'sh7FFFFFFF;
      end
      if (v < -64'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[W-1:0];
   endfunction

   function automatic logic signed [W-1:0] qround(input logic signed [63:0] p);
      logic signed [63:0] r;
      r = (p + 64'sd32768) >>> 16;
      return sat32(r);
   endfunction

   function automatic logic signed [W-1:0] clamp(input logic signed [W-1:0] v,
                                                 input logic [W-2:0] lim);
      logic signed [W-1:0] l;
      l = $signed({1'b0, lim});
      if (v > l) begin
         return l;
      end
      if (v < -l) begin
         return -l;
      end
      return v;
   endfunction

   function automatic logic signed [W-1:0] integ(input logic signed [W-1:0] sum,
                                                 input logic signed [W-1:0] err,
                                                 input logic [W-2:0] lim);
      logic signed [W-1:0] step;
      logic signed [W-1:0] s;
      step = err / ctp_pkg::LOOP_FREQ;
      s    = sat32(64'(sum) + 64'(step));
      return clamp(s, lim);
   endfunction

   ctp_pkg::req_type              item_ff;
   logic signed [W-1:0]           prev_ff, pint_ff, tint_ff, held_pitch_ff, held_climb_ff;
   logic signed [W-1:0]           err_ff, derr_ff;
   logic signed [ctp_pkg::ACC_W-1:0] acc_ff;
   logic signed [ctp_pkg::PROD_W-1:0] prod_ff;
   logic [ctp_pkg::THR_W-1:0]     thr_ff;

   logic signed [W-1:0]           mul_a, mul_b;
   logic signed [W-1:0]           diff, q, sp_raw, err_c;
   logic signed [ctp_pkg::ACC_W-1:0] acc_q;
   logic [ctp_pkg::DIV_W-1:0]     div_num, div_den, quotient;

   assign diff  = sat32(64'(item_ff.target_altitude) - 64'(item_ff.altitude));
   assign q     = qround(prod_ff);
   assign acc_q = acc_ff + ctp_pkg::ACC_W'(q);
   assign err_c = sat32(64'(held_climb_ff) - 64'(item_ff.vertical_speed));

   always_comb begin
      case (ctp_pkg::kind_type'(item_ff.kind))
         ctp_pkg::KIND_ALTITUDE: sp_raw = q;
         ctp_pkg::KIND_CLIMB:    sp_raw = item_ff.climb_request;
         default:                sp_raw = '0;
      endcase
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         ctp_pkg::OP_MUL_ALT: begin
            mul_a = $signed({1'b0, cfg.climb_gain});
            mul_b = diff;
         end
         ctp_pkg::OP_PPC: begin
            mul_a = W'(ctp_pkg::PITCH_PER_CLIMB);
            mul_b = held_climb_ff;
         end
         ctp_pkg::OP_PKP: begin
            mul_a = $signed({1'b0, cfg.pitch_kp});
            mul_b = err_ff;
         end
         ctp_pkg::OP_PKD: begin
            mul_a = $signed({1'b0, cfg.pitch_kd});
            mul_b = derr_ff;
         end
         ctp_pkg::OP_PKI: begin
            mul_a = $signed({1'b0, cfg.pitch_ki});
            mul_b = pint_ff;
         end
         ctp_pkg::OP_TPC: begin
            mul_a = W'(ctp_pkg::THROTTLE_PER_CLIMB);
            mul_b = held_climb_ff;
         end
         ctp_pkg::OP_TKP: begin
            mul_a = $signed({1'b0, cfg.throttle_kp});
            mul_b = err_ff;
         end
         ctp_pkg::OP_TKD: begin
            mul_a = W'(ctp_pkg::THROTTLE_KD);
            mul_b = derr_ff;
         end
         ctp_pkg::OP_TKI: begin
            mul_a = $signed({1'b0, cfg.throttle_ki});
            mul_b = tint_ff;
         end
         ctp_pkg::OP_THR_MUL: begin
            mul_a = acc_ff[W-1:0];
            mul_b = W'(ctp_pkg::MAX_THROTTLE);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Each integrator limit is the loop's sum bound in Q16.16 over its gain.
   assign div_num = cmd.div_throttle ? ctp_pkg::DIV_W'(ctp_pkg::THROTTLE_SUM_LIMIT * 65536)
                                     : ctp_pkg::DIV_W'(ctp_pkg::PITCH_SUM_LIMIT * 65536);
   assign div_den = cmd.div_throttle ? cfg.throttle_ki : cfg.pitch_ki;

   ctp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .numerator (div_num),
      .divisor   (div_den),
      .busy      (div_busy),
      .quotient  (quotient)
   );

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item;
      end
      prod_ff <= mul_a * mul_b;
      case (cmd.op)
         ctp_pkg::OP_ERROR:   err_ff  <= err_c;
         ctp_pkg::OP_DERR:    derr_ff <= sat32(64'(err_ff) - 64'(prev_ff));
         ctp_pkg::OP_PPC:     acc_ff  <= ctp_pkg::ACC_W'(item_ff.pitch_feedforward)
                                         + ctp_pkg::ACC_W'(ctp_pkg::PITCH_BIAS);
         ctp_pkg::OP_PKP,
         ctp_pkg::OP_PKD,
         ctp_pkg::OP_PKI,
         ctp_pkg::OP_TKP,
         ctp_pkg::OP_TKD,
         ctp_pkg::OP_TACC,
         ctp_pkg::OP_TSUM:    acc_ff  <= acc_q;
         ctp_pkg::OP_TPC:     acc_ff  <= ctp_pkg::ACC_W'({1'b0, cfg.base_throttle});
         ctp_pkg::OP_MANUAL: begin
            thr_ff <= (32'(item_ff.manual_throttle) > ctp_pkg::MAX_THROTTLE)
                      ? ctp_pkg::THR_W'(ctp_pkg::MAX_THROTTLE) : item_ff.manual_throttle;
         end
         ctp_pkg::OP_THR_END: begin
            if (acc_ff <= 0) begin
               thr_ff <= '0;
            end else if (64'(acc_ff) > ctp_pkg::THR_SUM_MAX) begin
               thr_ff <= ctp_pkg::THR_W'(ctp_pkg::MAX_THROTTLE);
            end else begin
               thr_ff <= prod_ff[ctp_pkg::THR_W+15:16];
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff       <= '0;
         pint_ff       <= '0;
         tint_ff       <= '0;
         held_pitch_ff <= '0;
         held_climb_ff <= '0;
      end else begin
         case (cmd.op)
            ctp_pkg::OP_SETPOINT: held_climb_ff <= clamp(sp_raw, cfg.climb_limit);
            ctp_pkg::OP_ERROR: begin
               if (!item_ff.airborne) begin
                  pint_ff <= '0;
                  tint_ff <= '0;
               end
            end
            ctp_pkg::OP_DERR: prev_ff <= err_ff;
            ctp_pkg::OP_INT_P: begin
               if (cfg.pitch_ki != '0) begin
                  pint_ff <= integ(pint_ff, err_ff, quotient);
               end
            end
            ctp_pkg::OP_INT_T: begin
               if (cfg.throttle_ki != '0) begin
                  tint_ff <= integ(tint_ff, err_ff, quotient);
               end
            end
            ctp_pkg::OP_TPC: held_pitch_ff <= sat32(64'(acc_q));
            default: begin
            end
         endcase
      end
   end

   assign result.pitch_command    = held_pitch_ff;
   assign result.throttle_command = thr_ff;
   assign result.climb_target     = held_climb_ff;

endmodule

### design/ctp_ctrl.sv
// Sequencer that steps the datapath through one control tick.
`timescale 1ns / 1ps
module ctp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                manual,
   input  ctp_pkg::status_type status,
   output logic                req_ready,
   output ctp_pkg::cmd_type    cmd
);

   typedef enum logic [4:0] {
      S_IDLE, S_MANUAL, S_MUL_ALT, S_SETPOINT, S_ERROR, S_DERR, S_WAIT_P, S_INT_P,
      S_PPC, S_PKP, S_PKD, S_PKI, S_TPC, S_TKP, S_TKD, S_TACC, S_WAIT_T, S_INT_T,
      S_TKI, S_TSUM, S_THR_MUL, S_THR_END, S_OUT
   } state_type;

   state_type state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= manual ? S_MANUAL : S_MUL_ALT;
               end
            end
            S_MANUAL:   state_ff <= S_OUT;
            S_MUL_ALT:  state_ff <= S_SETPOINT;
            S_SETPOINT: state_ff <= S_ERROR;
            S_ERROR:    state_ff <= S_DERR;
            S_DERR:     state_ff <= S_WAIT_P;
            S_WAIT_P: begin
               if (!status.div_busy) begin
                  state_ff <= S_INT_P;
               end
            end
            S_INT_P:    state_ff <= S_PPC;
            S_PPC:      state_ff <= S_PKP;
            S_PKP:      state_ff <= S_PKD;
            S_PKD:      state_ff <= S_PKI;
            S_PKI:      state_ff <= S_TPC;
            S_TPC:      state_ff <= S_TKP;
            S_TKP:      state_ff <= S_TKD;
            S_TKD:      state_ff <= S_TACC;
            S_TACC:     state_ff <= S_WAIT_T;
            S_WAIT_T: begin
               if (!status.div_busy) begin
                  state_ff <= S_INT_T;
               end
            end
            S_INT_T:    state_ff <= S_TKI;
            S_TKI:      state_ff <= S_TSUM;
            S_TSUM:     state_ff <= S_THR_MUL;
            S_THR_MUL:  state_ff <= S_THR_END;
            S_THR_END:  state_ff <= S_OUT;
            S_OUT: begin
               if (status.out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default:    state_ff <= S_IDLE;
         endcase
      end
   end

   always_comb begin
      cmd = '{op: ctp_pkg::OP_NONE, div_start: 1'b0, div_throttle: 1'b0, out_load: 1'b0};
      case (state_ff)
         S_MANUAL:   cmd.op = ctp_pkg::OP_MANUAL;
         S_MUL_ALT:  cmd.op = ctp_pkg::OP_MUL_ALT;
         S_SETPOINT: cmd.op = ctp_pkg::OP_SETPOINT;
         S_ERROR: begin
            cmd.op        = ctp_pkg::OP_ERROR;
            cmd.div_start = 1'b1;
         end
         S_DERR:     cmd.op = ctp_pkg::OP_DERR;
         S_INT_P: begin
            cmd.op           = ctp_pkg::OP_INT_P;
            cmd.div_start    = 1'b1;
            cmd.div_throttle = 1'b1;
         end
         S_PPC:      cmd.op = ctp_pkg::OP_PPC;
         S_PKP:      cmd.op = ctp_pkg::OP_PKP;
         S_PKD:      cmd.op = ctp_pkg::OP_PKD;
         S_PKI:      cmd.op = ctp_pkg::OP_PKI;
         S_TPC:      cmd.op = ctp_pkg::OP_TPC;
         S_TKP:      cmd.op = ctp_pkg::OP_TKP;
         S_TKD:      cmd.op = ctp_pkg::OP_TKD;
         S_TACC:     cmd.op = ctp_pkg::OP_TACC;
         S_WAIT_T,
         S_INT_T: begin
            cmd.op           = (state_ff == S_INT_T) ? ctp_pkg::OP_INT_T : ctp_pkg::OP_NONE;
            cmd.div_throttle = 1'b1;
         end
         S_TKI:      cmd.op = ctp_pkg::OP_TKI;
         S_TSUM:     cmd.op = ctp_pkg::OP_TSUM;
         S_THR_MUL:  cmd.op = ctp_pkg::OP_THR_MUL;
         S_THR_END:  cmd.op = ctp_pkg::OP_THR_END;
         S_OUT:      cmd.out_load = status.out_free;
         default:    cmd.op = ctp_pkg::OP_NONE;
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);

`ifndef ASSERT_OFF
   a_start_idle_div: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !status.div_busy)
      else $error("divider started while busy");
   a_idle_div_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !status.div_busy)
      else $error("divider still running between ticks");
   a_int_after_wait: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_INT_T |-> $past(state_ff == S_WAIT_T))
      else $error("throttle integrator updated without waiting for its limit");
`endif

endmodule

### design/climb_pitch_throttle_pid.sv
// Top level of the climb-rate, pitch and throttle controller.
`timescale 1ns / 1ps
// Each accepted tick yields one result. A manual-mode tick goes from its clamp state to the
// output state; any other tick may wait on the two 31-step integrator-limit divisions of
// the one shared bit-serial divider, with the gain products going one per cycle, save
// during those waits, through a single 32 x 32 multiplier. A new tick is taken once the
// previous one has reached the output register, even if that result still waits there.
module climb_pitch_throttle_pid (
   input  logic                           clock,
   input  logic                           reset,
   ctp_req_if.sink                        req_chan,
   ctp_rsp_if.source                      rsp_chan,
   input  logic                           csr_write_en,
   input  logic [ctp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ctp_pkg::CSR_DATA_W-1:0] csr_wdata
);

   ctp_pkg::cfg_type    cfg_ff;
   ctp_pkg::cmd_type    cmd;
   ctp_pkg::status_type status;
   ctp_pkg::rsp_type    result;
   ctp_pkg::rsp_type    rsp_data_ff;
   logic                rsp_valid_ff;
   logic                div_busy;
   logic                req_ready;
   logic                accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{climb_gain: '0, climb_limit: ctp_pkg::GAIN_W'(131072), pitch_kp: '0,
                     pitch_kd: '0, pitch_ki: '0, throttle_kp: '0, throttle_ki: '0,
                     base_throttle: '0};
      end else if (csr_write_en) begin
         case (ctp_pkg::csr_index_type'(csr_index))
            ctp_pkg::CSR_CLIMB_GAIN:      cfg_ff.climb_gain      <= csr_wdata;
            ctp_pkg::CSR_CLIMB_LIMIT:     cfg_ff.climb_limit     <= csr_wdata;
            ctp_pkg::CSR_PITCH_KP:        cfg_ff.pitch_kp        <= csr_wdata;
            ctp_pkg::CSR_PITCH_KD:        cfg_ff.pitch_kd        <= csr_wdata;
            ctp_pkg::CSR_PITCH_KI:        cfg_ff.pitch_ki        <= csr_wdata;
            ctp_pkg::CSR_THROTTLE_KP:     cfg_ff.throttle_kp     <= csr_wdata;
            ctp_pkg::CSR_THROTTLE_KI:     cfg_ff.throttle_ki     <= csr_wdata;
            ctp_pkg::CSR_BASE_THROTTLE:
               cfg_ff.base_throttle <= csr_wdata[ctp_pkg::CRUISE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign accept          = req_chan.valid && req_ready;
   assign req_chan.ready  = req_ready;
   assign status.div_busy = div_busy;
   assign status.out_free = !rsp_valid_ff || rsp_chan.ready;

   ctp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .manual    (req_chan.payload.kind == ctp_pkg::KIND_MANUAL),
      .status    (status),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   ctp_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .load     (accept),
      .item     (req_chan.payload),
      .cmd      (cmd),
      .div_busy (div_busy),
      .result   (result)
   );

   // Output register: a finished result waits here until its transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

endmodule

### test/climb_pitch_throttle_pid_tb.sv
// Self-checking testbench of the climb, pitch and throttle controller.
`timescale 1ns / 1ps
module climb_pitch_throttle_pid_tb;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 100;
   localparam int HOLD_CYCLES    = 600;

   logic clock;
   logic reset;
   logic csr_write_en;
   logic [ctp_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [ctp_pkg::CSR_DATA_W-1:0] csr_wdata;

   ctp_req_if req_chan ();
   ctp_rsp_if rsp_chan ();

   climb_pitch_throttle_pid uut (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Predictor configuration and controller state.
   longint gain_reg [8];
   longint prior_err, pitch_sum, thr_sum, last_pitch, last_climb;

   ctp_pkg::req_type tick_queue[$];
   ctp_pkg::rsp_type result_queue[$];
   int  errors;
   bit  idle_enable;
   int  hold_request;
   int  hold_seen;
   int  hold_cycles;
   int  idle_count;
   int  stall_count;
   int  quiet_cycles;

   function automatic longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint q_product(longint a, longint b);
      longint p;
      p = a * b + 32768;
      // Arithmetic shift gives the floor for negative values too.
      return clip32(p >>> 16);
   endfunction

   function automatic longint clip_abs(longint v, longint lim);
      if (v > lim) v = lim;
      if (v < -lim) v = -lim;
      return clip32(v);
   endfunction

   function automatic longint next_integral(longint sum, longint err, longint ki,
                                            longint lim_q);
      longint lim;
      lim = (lim_q * 65536) / ki;
      if (lim > 64'sd2147483647) lim = 64'sd2147483647;
      return clip_abs(clip32(sum + err / ctp_pkg::LOOP_FREQ), lim);
   endfunction

   function automatic ctp_pkg::rsp_type predict_tick(ctp_pkg::req_type t);
      ctp_pkg::rsp_type r;
      longint sp, err, derr, p, s, thr;
      thr = 0;
      if (ctp_pkg::kind_type'(t.kind) == ctp_pkg::KIND_MANUAL) begin
         thr = (t.manual_throttle > ctp_pkg::MAX_THROTTLE) ? ctp_pkg::MAX_THROTTLE
                                                           : t.manual_throttle;
      end else begin
         case (ctp_pkg::kind_type'(t.kind))
            ctp_pkg::KIND_ALTITUDE: sp = q_product(gain_reg[ctp_pkg::CSR_CLIMB_GAIN],
                              clip32(longint'(t.target_altitude) - longint'(t.altitude)));
            ctp_pkg::KIND_CLIMB:    sp = t.climb_request;
            default:                sp = 0;
         endcase
         sp = clip_abs(sp, gain_reg[ctp_pkg::CSR_CLIMB_LIMIT]);
         err = clip32(sp - longint'(t.vertical_speed));
         derr = clip32(err - prior_err);
         prior_err = err;
         if (!t.airborne) begin
            pitch_sum = 0;
            thr_sum = 0;
         end
         if (gain_reg[ctp_pkg::CSR_PITCH_KI] > 0)
            pitch_sum = next_integral(pitch_sum, err, gain_reg[ctp_pkg::CSR_PITCH_KI],
                                      ctp_pkg::PITCH_SUM_LIMIT);
         if (gain_reg[ctp_pkg::CSR_THROTTLE_KI] > 0)
            thr_sum = next_integral(thr_sum, err, gain_reg[ctp_pkg::CSR_THROTTLE_KI],
                                    ctp_pkg::THROTTLE_SUM_LIMIT);
         p = longint'(t.pitch_feedforward) + ctp_pkg::PITCH_BIAS
             + q_product(ctp_pkg::PITCH_PER_CLIMB, sp)
             + q_product(gain_reg[ctp_pkg::CSR_PITCH_KP], err)
             + q_product(gain_reg[ctp_pkg::CSR_PITCH_KD], derr)
             + q_product(gain_reg[ctp_pkg::CSR_PITCH_KI], pitch_sum);
         last_pitch = clip32(p);
         last_climb = sp;
         s = gain_reg[ctp_pkg::CSR_BASE_THROTTLE] + q_product(ctp_pkg::THROTTLE_PER_CLIMB, sp)
             + q_product(gain_reg[ctp_pkg::CSR_THROTTLE_KP], err)
             + q_product(ctp_pkg::THROTTLE_KD, derr)
             + q_product(gain_reg[ctp_pkg::CSR_THROTTLE_KI], thr_sum);
         if (s > 0) begin
            thr = (s * ctp_pkg::MAX_THROTTLE) >>> 16;
            if (thr > ctp_pkg::MAX_THROTTLE) thr = ctp_pkg::MAX_THROTTLE;
         end
      end
      r.pitch_command    = last_pitch[31:0];
      r.throttle_command = thr[ctp_pkg::THR_W-1:0];
      r.climb_target     = last_climb[31:0];
      return r;
   endfunction

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Driver: offers queued ticks, with random gaps while idling is enabled.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         idle_count <= 0;
      end else if (req_chan.valid && !req_chan.ready) begin
         // Hold the offered tick until the transfer happens.
      end else begin
         if (req_chan.valid) begin
            result_queue.push_back(predict_tick(req_chan.payload));
         end
         if (idle_count > 0) begin
            idle_count <= idle_count - 1;
            req_chan.valid <= 1'b0;
         end else if (idle_enable && $urandom_range(0, 5) == 0) begin
            idle_count <= $urandom_range(1, 8) - 1;
            req_chan.valid <= 1'b0;
         end else if (tick_queue.size() > 0) begin
            req_chan.payload <= tick_queue.pop_front();
            req_chan.valid <= 1'b1;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Monitor: checks each result transfer and drives ready with random stalls.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_count <= 0;
         quiet_cycles <= 0;
         hold_cycles <= 0;
         hold_seen <= 0;
      end else begin
         if ((rsp_chan.valid && rsp_chan.ready) || (req_chan.valid && req_chan.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (result_queue.size() == 0) begin
               $error("result with no tick pending: %p", rsp_chan.payload);
               errors++;
            end else begin
               ctp_pkg::rsp_type e;
               e = result_queue.pop_front();
               if (rsp_chan.payload.pitch_command !== e.pitch_command) begin
                  $error("pitch_command expected %0d got %0d", e.pitch_command,
                         rsp_chan.payload.pitch_command);
                  errors++;
               end
               if (rsp_chan.payload.throttle_command !== e.throttle_command) begin
                  $error("throttle_command expected %0d got %0d", e.throttle_command,
                         rsp_chan.payload.throttle_command);
                  errors++;
               end
               if (rsp_chan.payload.climb_target !== e.climb_target) begin
                  $error("climb_target expected %0d got %0d", e.climb_target,
                         rsp_chan.payload.climb_target);
                  errors++;
               end
            end
         end
         if (hold_cycles > 0) begin
            rsp_chan.ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
         end else if (hold_seen != hold_request) begin
            // A long hold-off starts; its length is counted here.
            hold_seen <= hold_request;
            hold_cycles <= HOLD_CYCLES - 1;
            rsp_chan.ready <= 1'b0;
         end else if (stall_count > 0) begin
            stall_count <= stall_count - 1;
            rsp_chan.ready <= 1'b0;
         end else if (idle_enable && $urandom_range(0, 5) == 0) begin
            stall_count <= $urandom_range(1, 8) - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("climb_pitch_throttle_pid: mismatch");
         $finish;
      end
   end

   task automatic write_reg(ctp_pkg::csr_index_type idx, longint value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value[ctp_pkg::CSR_DATA_W-1:0];
      if (idx == ctp_pkg::CSR_BASE_THROTTLE) gain_reg[idx] = value & 64'h1FFFF;
      else gain_reg[idx] = value & 64'h7FFFFFFF;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Waits until every queued tick has been sent and every result has come back.
   task automatic drain;
      while (tick_queue.size() > 0 || req_chan.valid || result_queue.size() > 0) begin
         @(posedge clock);
         #1;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic longint pick_gain(int sel);
      case (sel)
         0: return 0;
         1: return 64'h7FFFFFFF;
         2: return $urandom_range(0, 65536);
         3: return $urandom_range(0, 2048);
         default: return $urandom() & 64'h7FFFFFFF;
      endcase
   endfunction

   function automatic logic [31:0] pick_q(int extreme);
      case ($urandom_range(0, extreme ? 4 : 2))
         0: return $urandom_range(0, 20 * 65536) - 10 * 65536;
         1: return $urandom_range(0, 400 * 65536) - 200 * 65536;
         2: return $urandom();
         3: return 32'h7FFFFFFF;
         default: return 32'h80000000;
      endcase
   endfunction

   function automatic ctp_pkg::req_type random_tick();
      ctp_pkg::req_type t;
      t.kind = 2'($urandom_range(0, 3));
      t.airborne = ($urandom_range(0, 9) != 0);
      t.target_altitude = pick_q(1);
      t.altitude = ($urandom_range(0, 1)) ? t.target_altitude - ($urandom_range(0, 655360)
                   - 327680) : pick_q(1);
      t.climb_request = pick_q(1);
      t.manual_throttle = ($urandom_range(0, 3) == 0) ? 14'($urandom())
                                                      : 14'($urandom_range(0, 9600));
      t.pitch_feedforward = pick_q(1);
      t.vertical_speed = pick_q(1);
      return t;
   endfunction

   task automatic load_settings(int style);
      int i;
      for (i = 0; i < 8; i++) begin
         if (i == ctp_pkg::CSR_BASE_THROTTLE)
            write_reg(ctp_pkg::csr_index_type'(i), style == 1 ? 64'h1FFFF :
                      style == 0 ? 0 : $urandom_range(0, 65536));
         else
            write_reg(ctp_pkg::csr_index_type'(i), style == 1 ? 64'h7FFFFFFF :
                      style == 0 ? 0 : pick_gain($urandom_range(2, 4)));
      end
   endtask

   initial begin
      ctp_pkg::req_type t;
      int phase, n;
      errors = 0;
      idle_enable = 0;
      hold_request = 0;
      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_index = ctp_pkg::CSR_CLIMB_GAIN;
      csr_wdata = '0;
      req_chan.valid = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready = 1'b0;
      gain_reg = '{0, 131072, 0, 0, 0, 0, 0, 0};
      prior_err = 0; pitch_sum = 0; thr_sum = 0; last_pitch = 0; last_climb = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed ticks: every mode, field extremes, manual hold.
      write_reg(ctp_pkg::CSR_PITCH_KP, 65536);
      write_reg(ctp_pkg::CSR_PITCH_KI, 3);
      write_reg(ctp_pkg::CSR_THROTTLE_KI, 1);
      write_reg(ctp_pkg::CSR_CLIMB_GAIN, 32768);
      for (n = 0; n < 20; n++) begin
         t = '0;
         t.kind = 2'(n % 4);
         t.airborne = (n % 7 != 3);
         t.target_altitude = (n % 2) ? 32'h7FFFFFFF : 32'h80000000;
         t.altitude = (n % 3 == 0) ? 32'h80000000 : 32'h7FFFFFFF;
         t.climb_request = (n % 2) ? 32'h80000000 : 32'h7FFFFFFF;
         t.manual_throttle = (n < 8) ? 14'h3FFF : (n < 12 ? 14'd9600 : 14'd0);
         t.pitch_feedforward = (n % 5 == 0) ? 32'h7FFFFFFF : 32'h80000000;
         t.vertical_speed = (n % 3 == 1) ? 32'h7FFFFFFF : 32'h80000000;
         tick_queue.push_back(t);
      end
      drain();

      // Random phases, each with new settings; the extremes come first.
      idle_enable = 1;
      for (phase = 0; phase < 10; phase++) begin
         load_settings(phase < 2 ? phase : 2);
         for (n = 0; n < 190; n++) tick_queue.push_back(random_tick());
         if (phase == 3) begin
            // Long receiver hold-off while the sender keeps offering.
            hold_request++;
         end
         drain();
      end

      // Final part with no idling at all.
      idle_enable = 0;
      load_settings(2);
      for (n = 0; n < 100; n++) tick_queue.push_back(random_tick());
      drain();

      if (errors == 0)
         $display("climb_pitch_throttle_pid: match");
      else
         $display("climb_pitch_throttle_pid: mismatch");
      $finish;
   end
endmodule
